FILE: hw/rtl/hccm_pkg.sv
package hccm_pkg;

   // field widths
   localparam int SENSOR_W   = 13;
   localparam int HOUR_W     = 5;
   localparam int SP_W       = 7;
   localparam int MODE_W     = 3;
   localparam int TONE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   // scaled temperature, 1/160 degree F: 9*s + 5120 needs 17 bits signed, one spare
   localparam int T10_W = 18;

   localparam logic [SP_W-1:0] SP_MAX = '1;

   // reset values of the setpoints and the night window
   localparam logic [SP_W-1:0]   DAY_HEAT_RST    = 7'd75;
   localparam logic [SP_W-1:0]   DAY_COOL_RST    = 7'd80;
   localparam logic [SP_W-1:0]   NIGHT_HEAT_RST  = 7'd70;
   localparam logic [SP_W-1:0]   NIGHT_COOL_RST  = 7'd85;
   localparam logic [HOUR_W-1:0] NIGHT_BEGIN_RST = 5'd23;
   localparam logic [HOUR_W-1:0] NIGHT_END_RST   = 5'd6;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DAY_HEAT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAY_COOL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_HEAT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_COOL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_BEGIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_END   = 3'd5;

   typedef enum logic [MODE_W-1:0] {
      MODE_HEAT_OFF = 3'd0,
      MODE_HEAT_ON  = 3'd1,
      MODE_COOL_OFF = 3'd2,
      MODE_COOL_ON  = 3'd3,
      MODE_OFF      = 3'd4
   } mode_type;

   typedef enum logic [TONE_W-1:0] {
      TONE_NONE   = 2'd0,
      TONE_ADJUST = 2'd1,
      TONE_MODE   = 2'd2
   } tone_type;

   // setpoint in whole degrees F scaled to 1/160 degree: sp*128 + sp*32
   function automatic logic signed [T10_W-1:0] sp_scaled(input logic [SP_W-1:0] sp);
      logic [T10_W-1:0] a;
      logic [T10_W-1:0] b;
      a = {{(T10_W-SP_W-7){1'b0}}, sp, 7'b0};
      b = {{(T10_W-SP_W-5){1'b0}}, sp, 5'b0};
      return $signed(a + b);
   endfunction

endpackage

FILE: hw/rtl/heat_cool_thermostat_mode_controller_core.sv
// Channel  Dir  Ports                                  Item
// req      in   req_valid / req_ready                  sensor, hour, three buttons
// rsp      out  rsp_valid / rsp_ready                  mode, drives, setpoint, temp, night, tone
// csr      in   csr_valid / csr_ready, index, data     one register write
//
// An accepted item is held in the input register; when the result register is free or being
// read, the mode/setpoint update and the conversion are written into the result register,
// which offers the result. One item is accepted every cycle while rsp_ready is high; the mode and
// setpoint registers update on the same edge as the result register.
// Reset (synchronous) loads mode off, setpoints 75/80 F and the csr reset values.
// A stalled rsp holds its result; the input register takes one more item, then req_ready drops.
module heat_cool_thermostat_mode_controller_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // input items
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [hccm_pkg::SENSOR_W-1:0]   req_sensor_celsius,
   input  logic [hccm_pkg::HOUR_W-1:0]            req_hour_of_day,
   input  logic                                   req_button_down,
   input  logic                                   req_button_up,
   input  logic                                   req_button_mode,
   // result items
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [hccm_pkg::MODE_W-1:0]            rsp_mode_now,
   output logic                                   rsp_heater_drive,
   output logic                                   rsp_cooler_drive,
   output logic [hccm_pkg::SP_W-1:0]              rsp_active_setpoint,
   output logic signed [hccm_pkg::SENSOR_W-1:0]   rsp_temp_fahrenheit,
   output logic                                   rsp_night_active,
   output logic [hccm_pkg::TONE_W-1:0]            rsp_tone_request,
   // configuration writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [hccm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hccm_pkg::CSR_DATA_W-1:0]        csr_data
);
   import hccm_pkg::*;

   // configuration
   logic [SP_W-1:0]    night_heat_ff;
   logic [SP_W-1:0]    night_cool_ff;
   logic [HOUR_W-1:0]  night_begin_ff;
   logic [HOUR_W-1:0]  night_end_ff;

   // input register
   logic                        in_valid_ff;
   logic signed [SENSOR_W-1:0]  sensor_ff;
   logic [HOUR_W-1:0]           hour_ff;
   logic                        down_ff;
   logic                        up_ff;
   logic                        mode_btn_ff;

   // controller state
   mode_type          mode_ff;
   mode_type          mode_in;
   logic [SP_W-1:0]   heat_sp_ff;
   logic [SP_W-1:0]   heat_sp_in;
   logic [SP_W-1:0]   cool_sp_ff;
   logic [SP_W-1:0]   cool_sp_in;
   tone_type          tone_in;

   // result register
   logic                        rsp_valid_ff;
   mode_type                    rsp_mode_ff;
   logic                        rsp_heater_ff;
   logic                        rsp_cooler_ff;
   logic [SP_W-1:0]             rsp_sp_ff;
   logic signed [SENSOR_W-1:0]  rsp_temp_ff;
   logic                        rsp_night_ff;
   tone_type                    rsp_tone_ff;

   // datapath
   logic                        advance;
   logic                        night;
   logic signed [T10_W-1:0]     t10;
   logic signed [SENSOR_W-1:0]  temp_f;
   logic [SP_W-1:0]             heat_forced;
   logic [SP_W-1:0]             cool_forced;
   logic [SP_W-1:0]             fam_sp;
   logic [SP_W-1:0]             fam_adj;
   logic signed [T10_W-1:0]     fam_scaled;
   logic signed [T10_W-1:0]     heat_scaled;
   logic signed [T10_W-1:0]     cool_scaled;
   logic                        heater_in;
   logic                        cooler_in;
   logic [SP_W-1:0]             sp_out_in;

   // handshake: the input register moves on whenever the result register frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // configuration registers; day setpoints only matter at reset, where they
   // always hold their reset values, so writes to them are taken and dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         night_heat_ff  <= NIGHT_HEAT_RST;
         night_cool_ff  <= NIGHT_COOL_RST;
         night_begin_ff <= NIGHT_BEGIN_RST;
         night_end_ff   <= NIGHT_END_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NIGHT_HEAT:  night_heat_ff  <= csr_data[SP_W-1:0];
            CSR_NIGHT_COOL:  night_cool_ff  <= csr_data[SP_W-1:0];
            CSR_NIGHT_BEGIN: night_begin_ff <= csr_data[HOUR_W-1:0];
            CSR_NIGHT_END:   night_end_ff   <= csr_data[HOUR_W-1:0];
            CSR_DAY_HEAT,
            CSR_DAY_COOL:    ;
            default:         ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sensor_ff   <= req_sensor_celsius;
         hour_ff     <= req_hour_of_day;
         down_ff     <= req_button_down;
         up_ff       <= req_button_up;
         mode_btn_ff <= req_button_mode;
      end
   end

   // temperature conversion
   hccm_temp_conv u_conv (
      .sensor_celsius  (sensor_ff),
      .temp_scaled     (t10),
      .temp_fahrenheit (temp_f)
   );

   assign night = (hour_ff >= night_begin_ff) || (hour_ff < night_end_ff);

   // night forcing and button adjust of the active family's setpoint
   assign heat_forced = night ? night_heat_ff : heat_sp_ff;
   assign cool_forced = night ? night_cool_ff : cool_sp_ff;

   always_comb begin
      if (mode_ff == MODE_COOL_OFF || mode_ff == MODE_COOL_ON) begin
         fam_sp = cool_forced;
      end else begin
         fam_sp = heat_forced;
      end
      if (down_ff) begin
         fam_adj = (fam_sp == '0) ? '0 : fam_sp - 1'b1;
      end else if (up_ff) begin
         fam_adj = (fam_sp == SP_MAX) ? SP_MAX : fam_sp + 1'b1;
      end else begin
         fam_adj = fam_sp;
      end
   end

   assign fam_scaled  = sp_scaled(fam_adj);
   assign heat_scaled = sp_scaled(heat_sp_ff);
   assign cool_scaled = sp_scaled(cool_sp_ff);

   // next state
   always_comb begin
      mode_in    = mode_ff;
      heat_sp_in = heat_sp_ff;
      cool_sp_in = cool_sp_ff;
      tone_in    = TONE_NONE;
      case (mode_ff)
         MODE_HEAT_OFF,
         MODE_HEAT_ON: begin
            heat_sp_in = fam_adj;
            if (down_ff || up_ff) begin
               tone_in = TONE_ADJUST;
            end
            if (mode_ff == MODE_HEAT_OFF) begin
               if (t10 < fam_scaled) begin
                  mode_in = MODE_HEAT_ON;
               end
            end else if (t10 > fam_scaled) begin
               mode_in = MODE_HEAT_OFF;
            end
            if (mode_btn_ff) begin
               mode_in = (t10 > cool_scaled) ? MODE_COOL_ON : MODE_COOL_OFF;
               tone_in = TONE_MODE;
            end
         end
         MODE_COOL_OFF,
         MODE_COOL_ON: begin
            cool_sp_in = fam_adj;
            if (down_ff || up_ff) begin
               tone_in = TONE_ADJUST;
            end
            if (mode_ff == MODE_COOL_OFF) begin
               if (t10 > fam_scaled) begin
                  mode_in = MODE_COOL_ON;
               end
            end else if (t10 < fam_scaled) begin
               mode_in = MODE_COOL_OFF;
            end
            if (mode_btn_ff) begin
               mode_in = MODE_OFF;
               tone_in = TONE_MODE;
            end
         end
         default: begin
            // off mode: no forcing, no adjust
            mode_in = MODE_OFF;
            if (mode_btn_ff) begin
               mode_in = (t10 < heat_scaled) ? MODE_HEAT_ON : MODE_HEAT_OFF;
               tone_in = TONE_MODE;
            end
         end
      endcase
   end

   // outputs from the new mode
   always_comb begin
      heater_in = 1'b0;
      cooler_in = 1'b0;
      sp_out_in = '0;
      case (mode_in)
         MODE_HEAT_OFF: sp_out_in = heat_sp_in;
         MODE_HEAT_ON: begin
            heater_in = 1'b1;
            sp_out_in = heat_sp_in;
         end
         MODE_COOL_OFF: sp_out_in = cool_sp_in;
         MODE_COOL_ON: begin
            cooler_in = 1'b1;
            sp_out_in = cool_sp_in;
         end
         default: sp_out_in = '0;
      endcase
   end

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OFF;
         heat_sp_ff <= DAY_HEAT_RST;
         cool_sp_ff <= DAY_COOL_RST;
      end else if (advance) begin
         mode_ff    <= mode_in;
         heat_sp_ff <= heat_sp_in;
         cool_sp_ff <= cool_sp_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mode_ff   <= mode_in;
         rsp_heater_ff <= heater_in;
         rsp_cooler_ff <= cooler_in;
         rsp_sp_ff     <= sp_out_in;
         rsp_temp_ff   <= temp_f;
         rsp_night_ff  <= night;
         rsp_tone_ff   <= tone_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mode_now        = rsp_mode_ff;
   assign rsp_heater_drive    = rsp_heater_ff;
   assign rsp_cooler_drive    = rsp_cooler_ff;
   assign rsp_active_setpoint = rsp_sp_ff;
   assign rsp_temp_fahrenheit = rsp_temp_ff;
   assign rsp_night_active    = rsp_night_ff;
   assign rsp_tone_request    = rsp_tone_ff;

endmodule

FILE: hw/rtl/hccm_temp_conv.sv
module hccm_temp_conv (
   input  logic signed [hccm_pkg::SENSOR_W-1:0] sensor_celsius,
   output logic signed [hccm_pkg::T10_W-1:0]    temp_scaled,
   output logic signed [hccm_pkg::SENSOR_W-1:0] temp_fahrenheit
);
   import hccm_pkg::*;

   // half of C to F: (9*s + 5120) in 1/160 F, then round half up to 1/16 F
   localparam logic signed [T10_W-1:0] T10_OFFSET = 18'sd5120;
   localparam logic signed [T10_W-1:0] T10_ROUND  = 18'sd5;
   // bias keeps the dividend positive; it is a multiple of ten
   localparam logic signed [T10_W-1:0] DIV_BIAS   = 18'sd32000;
   localparam int                      M_W        = 17;
   localparam int                      PROD_W     = 2 * M_W;
   localparam int                      RECIP_SH   = 20;
   // ceil(2^20 / 10), exact for dividends below 2^18
   localparam logic [M_W-1:0]          RECIP_10   = 17'd104858;
   localparam int                      Q_W        = PROD_W - RECIP_SH;
   localparam logic signed [Q_W:0]     Q_BIAS     = 15'sd3200;
   localparam logic signed [Q_W:0]     TF_MAX     = 15'sd4095;
   localparam logic signed [Q_W:0]     TF_MIN     = -15'sd4096;

   logic signed [T10_W-1:0]  s_ext;
   logic signed [T10_W-1:0]  biased;
   logic [M_W-1:0]           dividend;
   logic [PROD_W-1:0]        prod;
   logic [Q_W-1:0]           quot;
   logic signed [Q_W:0]      q;

   // 9*s + 5120
   assign s_ext       = {{(T10_W-SENSOR_W){sensor_celsius[SENSOR_W-1]}}, sensor_celsius};
   assign temp_scaled = (s_ext <<< 3) + s_ext + T10_OFFSET;

   // floor((t10 + 5) / 10) by reciprocal multiply on the biased value
   assign biased   = temp_scaled + T10_ROUND + DIV_BIAS;
   assign dividend = biased[M_W-1:0];
   assign prod     = {{(PROD_W-M_W){1'b0}}, dividend} * {{(PROD_W-M_W){1'b0}}, RECIP_10};
   assign quot     = prod[PROD_W-1:RECIP_SH];
   assign q        = $signed({1'b0, quot}) - Q_BIAS;

   // clamp to the 13-bit signed field
   always_comb begin
      if (q > TF_MAX) begin
         temp_fahrenheit = TF_MAX[SENSOR_W-1:0];
      end else if (q < TF_MIN) begin
         temp_fahrenheit = TF_MIN[SENSOR_W-1:0];
      end else begin
         temp_fahrenheit = q[SENSOR_W-1:0];
      end
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import hccm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_ITEMS = 100;

   // indexes past the register list, writes there are ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct packed {
      logic signed [SENSOR_W-1:0] celsius;
      logic [HOUR_W-1:0]          hour;
      logic                       down;
      logic                       up;
      logic                       mode_btn;
   } reading_type;

   typedef struct packed {
      mode_type                   mode;
      logic                       heater;
      logic                       cooler;
      logic [SP_W-1:0]            setpoint;
      logic signed [SENSOR_W-1:0] temp_f;
      logic                       night;
      tone_type                   tone;
   } status_type;

   typedef struct packed {
      reading_type in;
      logic        typed;
      status_type  want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SENSOR_W-1:0] req_sensor_celsius = '0;
   logic [HOUR_W-1:0]          req_hour_of_day = '0;
   logic                       req_button_down = 1'b0;
   logic                       req_button_up = 1'b0;
   logic                       req_button_mode = 1'b0;

   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [MODE_W-1:0]          rsp_mode_now;
   logic                       rsp_heater_drive;
   logic                       rsp_cooler_drive;
   logic [SP_W-1:0]            rsp_active_setpoint;
   logic signed [SENSOR_W-1:0] rsp_temp_fahrenheit;
   logic                       rsp_night_active;
   logic [TONE_W-1:0]          rsp_tone_request;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   // thermostat state and registers as the testbench sees them;
   // day setpoints only matter at a reset load, so they are not tracked
   mode_type          model_mode = MODE_OFF;
   logic [SP_W-1:0]   heat_sp = DAY_HEAT_RST;
   logic [SP_W-1:0]   cool_sp = DAY_COOL_RST;
   logic [SP_W-1:0]   cfg_night_heat = NIGHT_HEAT_RST;
   logic [SP_W-1:0]   cfg_night_cool = NIGHT_COOL_RST;
   logic [HOUR_W-1:0] cfg_night_begin = NIGHT_BEGIN_RST;
   logic [HOUR_W-1:0] cfg_night_end = NIGHT_END_RST;

   status_type     pending_status[$];
   script_row_type script[$];
   int             mismatch_count = 0;
   int unsigned    cycle_count = 0;
   int             rsp_hold = 0;
   logic           no_idle = 1'b0;

   heat_cool_thermostat_mode_controller_core DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int idle_draw();
      return no_idle ? 0 : int'($urandom_range(0, 10));
   endfunction

   // one setpoint step, saturating at both ends
   function automatic logic [SP_W-1:0] nudge(logic [SP_W-1:0] sp, logic down);
      if (down)
         return (sp == '0) ? sp : sp - 1'b1;
      return (sp == SP_MAX) ? sp : sp + 1'b1;
   endfunction

   // one tick of the controller: updates the state copy, returns the expected item
   function automatic status_type thermostat_tick(reading_type r);
      status_type st;
      int         cel, t10, n, q, heat_lim, cool_lim;
      logic       night;
      mode_type   next;
      tone_type   tone;
      cel = $signed(r.celsius);
      t10 = 9 * cel + 5120;
      // round half up in 1/16 F, then clamp to the output width
      n = t10 + 5;
      q = n / 10;
      if (n % 10 != 0 && n < 0)
         q = q - 1;
      if (q > 4095)
         q = 4095;
      if (q < -4096)
         q = -4096;
      night = (r.hour >= cfg_night_begin) || (r.hour < cfg_night_end);
      next = model_mode;
      tone = TONE_NONE;
      case (model_mode)
         MODE_HEAT_OFF, MODE_HEAT_ON: begin
            if (night)
               heat_sp = cfg_night_heat;
            if (r.down || r.up) begin
               heat_sp = nudge(heat_sp, r.down);
               tone = TONE_ADJUST;
            end
            heat_lim = 160 * heat_sp;
            cool_lim = 160 * cool_sp;
            if (model_mode == MODE_HEAT_OFF) begin
               if (t10 < heat_lim)
                  next = MODE_HEAT_ON;
            end else if (t10 > heat_lim) begin
               next = MODE_HEAT_OFF;
            end
            if (r.mode_btn) begin
               next = (t10 > cool_lim) ? MODE_COOL_ON : MODE_COOL_OFF;
               tone = TONE_MODE;
            end
         end
         MODE_COOL_OFF, MODE_COOL_ON: begin
            if (night)
               cool_sp = cfg_night_cool;
            if (r.down || r.up) begin
               cool_sp = nudge(cool_sp, r.down);
               tone = TONE_ADJUST;
            end
            cool_lim = 160 * cool_sp;
            if (model_mode == MODE_COOL_OFF) begin
               if (t10 > cool_lim)
                  next = MODE_COOL_ON;
            end else if (t10 < cool_lim) begin
               next = MODE_COOL_OFF;
            end
            if (r.mode_btn) begin
               next = MODE_OFF;
               tone = TONE_MODE;
            end
         end
         default: begin
            heat_lim = 160 * heat_sp;
            next = MODE_OFF;
            if (r.mode_btn) begin
               next = (t10 < heat_lim) ? MODE_HEAT_ON : MODE_HEAT_OFF;
               tone = TONE_MODE;
            end
         end
      endcase
      model_mode = next;
      st.mode = next;
      st.heater = (next == MODE_HEAT_ON);
      st.cooler = (next == MODE_COOL_ON);
      if (next == MODE_HEAT_OFF || next == MODE_HEAT_ON)
         st.setpoint = heat_sp;
      else if (next == MODE_COOL_OFF || next == MODE_COOL_ON)
         st.setpoint = cool_sp;
      else
         st.setpoint = '0;
      st.temp_f = q[SENSOR_W-1:0];
      st.night = night;
      st.tone = tone;
      return st;
   endfunction

   function automatic script_row_type row(int cel, int hr, logic dn, logic upb, logic mb,
                                          logic typed, mode_type m, int sp, int tf,
                                          logic nt, tone_type tn);
      script_row_type s;
      s.in.celsius = cel[SENSOR_W-1:0];
      s.in.hour = hr[HOUR_W-1:0];
      s.in.down = dn;
      s.in.up = upb;
      s.in.mode_btn = mb;
      s.typed = typed;
      s.want.mode = m;
      s.want.heater = (m == MODE_HEAT_ON);
      s.want.cooler = (m == MODE_COOL_ON);
      s.want.setpoint = sp[SP_W-1:0];
      s.want.temp_f = tf[SENSOR_W-1:0];
      s.want.night = nt;
      s.want.tone = tn;
      return s;
   endfunction

   // random sample: half of the draws close to the live setpoint so the comparisons flip often
   function automatic reading_type make_reading();
      reading_type r;
      int pick, sp, aim, offs, cel;
      pick = $urandom_range(0, 9);
      sp = (model_mode == MODE_COOL_OFF || model_mode == MODE_COOL_ON) ? cool_sp : heat_sp;
      aim = (160 * sp - 5120) / 9;
      offs = $urandom_range(0, 40);
      if (pick < 5)
         cel = aim + offs - 20;
      else if (pick < 8)
         cel = int'($urandom_range(0, 3040)) - 640;
      else
         cel = $urandom;
      r.celsius = cel[SENSOR_W-1:0];
      if ($urandom_range(0, 9) < 8)
         r.hour = HOUR_W'($urandom_range(0, 23));
      else
         r.hour = HOUR_W'($urandom_range(0, 31));
      r.down = ($urandom_range(0, 3) == 0);
      r.up = ($urandom_range(0, 3) == 0);
      r.mode_btn = ($urandom_range(0, 7) == 0);
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] draw_setting(int top);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return CSR_DATA_W'($urandom_range(0, top));
      endcase
   endfunction

   // present one item, hold it until taken, then record what it should produce
   task automatic push_reading(input reading_type r, input logic typed,
                               input status_type want);
      int         gap;
      status_type due;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sensor_celsius <= r.celsius;
      req_hour_of_day <= r.hour;
      req_button_down <= r.down;
      req_button_up <= r.up;
      req_button_mode <= r.mode_btn;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due = thermostat_tick(r);
      pending_status.push_back(typed ? want : due);
   endtask

   // csr valid is left high so back-to-back writes never drop it
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_NIGHT_HEAT:  cfg_night_heat = val;
         CSR_NIGHT_COOL:  cfg_night_cool = val;
         CSR_NIGHT_BEGIN: cfg_night_begin = val[HOUR_W-1:0];
         CSR_NIGHT_END:   cfg_night_end = val[HOUR_W-1:0];
         default: ;
      endcase
   endtask

   // first two phases pin the extremes, the rest draw settings at random
   task automatic load_settings(input int phase);
      logic [CSR_DATA_W-1:0] dh, dc, nh, nc, nb, ne;
      dh = draw_setting(127);
      dc = draw_setting(127);
      nh = draw_setting(127);
      nc = draw_setting(127);
      nb = draw_setting(23);
      ne = draw_setting(23);
      if (phase == 0) begin
         // night all day, night setpoints at the saturation limits
         dh = '0; dc = '1; nh = '0; nc = '1; nb = '0; ne = '0;
      end else if (phase == 1) begin
         // night only at hour 31
         dh = '1; dc = '0; nh = '1; nc = '0; nb = '1; ne = '0;
      end
      write_reg(CSR_DAY_HEAT, dh);
      write_reg(CSR_DAY_COOL, dc);
      write_reg(CSR_NIGHT_HEAT, nh);
      write_reg(CSR_NIGHT_COOL, nc);
      write_reg(CSR_NIGHT_BEGIN, nb);
      write_reg(CSR_NIGHT_END, ne);
      if ($urandom_range(0, 1))
         write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                   CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // result side: random stalls, every accepted item checked against the oldest expectation
   always @(posedge clock) begin : result_check
      status_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_status.size() == 0) begin
               $display("%0t: result item with nothing expected", $time);
               mismatch_count++;
            end else begin
               want = pending_status.pop_front();
               check_field("mode_now", want.mode, rsp_mode_now);
               check_field("heater_drive", want.heater, rsp_heater_drive);
               check_field("cooler_drive", want.cooler, rsp_cooler_drive);
               check_field("active_setpoint", want.setpoint, rsp_active_setpoint);
               check_field("temp_fahrenheit", $signed(want.temp_f), rsp_temp_fahrenheit);
               check_field("night_active", want.night, rsp_night_active);
               check_field("tone_request", want.tone, rsp_tone_request);
            end
            rsp_hold = idle_draw();
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   initial begin
      int         i, p, k;
      status_type blank;
      blank = '0;

      // directed items under reset settings; typed expectations where obvious
      script.push_back(row(0, 12, 0, 0, 0, 1, MODE_OFF, 0, 512, 0, TONE_NONE));
      script.push_back(row(4095, 31, 0, 0, 0, 1, MODE_OFF, 0, 4095, 1, TONE_NONE));
      script.push_back(row(-4096, 0, 0, 0, 0, 1, MODE_OFF, 0, -3174, 1, TONE_NONE));
      // the down and up buttons do nothing while off
      script.push_back(row(0, 12, 1, 1, 0, 1, MODE_OFF, 0, 512, 0, TONE_NONE));
      script.push_back(row(0, 12, 0, 0, 1, 1, MODE_HEAT_ON, 75, 512, 0, TONE_MODE));
      script.push_back(row(0, 12, 0, 1, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      // down wins over up
      script.push_back(row(0, 12, 1, 1, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(2400, 12, 0, 0, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(0, 12, 0, 1, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      // sample of 800 lands exactly on 77 F: no switching at equality
      script.push_back(row(800, 12, 0, 1, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(801, 12, 0, 0, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(800, 12, 0, 0, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      // night forcing of the heat setpoint
      script.push_back(row(0, 23, 0, 0, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(800, 5, 0, 0, 1, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(0, 3, 0, 0, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(0, 12, 1, 0, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(2400, 12, 0, 0, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(0, 12, 0, 0, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(2400, 12, 0, 0, 1, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(2400, 12, 0, 0, 1, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      // hour beyond 23 still counts as night
      script.push_back(row(-4096, 24, 0, 0, 1, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(4095, 31, 0, 0, 0, 0, MODE_OFF, 0, 0, 0, TONE_NONE));
      script.push_back(row(0, 12, 0, 0, 1, 0, MODE_OFF, 0, 0, 0, TONE_NONE));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < script.size(); i++)
         push_reading(script[i].in, script[i].typed, script[i].want);
      req_valid <= 1'b0;

      // random phases, each under its own register settings
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         load_settings(p);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 25 == 0)
               no_idle = ($urandom_range(0, 4) == 0);
            push_reading(make_reading(), 1'b0, blank);
         end
         req_valid <= 1'b0;
      end
      wait_idle();

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: heat_cool_thermostat_mode_controller_core.f
hw/rtl/hccm_pkg.sv
hw/rtl/hccm_temp_conv.sv
hw/rtl/heat_cool_thermostat_mode_controller_core.sv
test/testbench.sv
